// ----- rtl/bpd_pkg.sv -----
// ----------------------------------------------------------------------------
// BASIC detokenizer package
// Shared types, codes and the keyword table of the listing generator.
// ----------------------------------------------------------------------------
package bpd_pkg;

  // Parse phases of the front end.
  localparam logic [2:0] PH_LOAD_LO = 3'd0;
  localparam logic [2:0] PH_LOAD_HI = 3'd1;
  localparam logic [2:0] PH_LINK_LO = 3'd2;
  localparam logic [2:0] PH_LINK_HI = 3'd3;
  localparam logic [2:0] PH_NUM_LO  = 3'd4;
  localparam logic [2:0] PH_NUM_HI  = 3'd5;
  localparam logic [2:0] PH_BODY    = 3'd6;
  localparam logic [2:0] PH_DONE    = 3'd7;

  // Job kinds handed from the front end to the back end.
  localparam logic [1:0] JOB_NUMBER  = 2'd0;
  localparam logic [1:0] JOB_CHAR    = 2'd1;
  localparam logic [1:0] JOB_KEYWORD = 2'd2;
  localparam logic [1:0] JOB_CR      = 2'd3;

  localparam logic [7:0] KW_FIRST = 8'h80;
  localparam logic [7:0] KW_LAST  = 8'hCB;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam int KW_COUNT = 76;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] data;    // line number, character or token
    logic        eof_cr;  // append a CR after the job
  } job_t;

  // Keywords are right-justified in 64 bits, zero padded.
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    "END", "FOR", "NEXT", "DATA", "INPUT#", "INPUT", "DIM", "READ",
    "LET", "GOTO", "RUN", "IF", "RESTORE", "GOSUB", "RETURN", "REM",
    "STOP", "ON", "WAIT", "LOAD", "SAVE", "VERIFY", "DEF", "POKE",
    "PRINT#", "PRINT", "CONT", "LIST", "CLR", "CMD", "SYS", "OPEN",
    "CLOSE", "GET", "NEW", "TAB(", "TO", "FN", "SPC(", "THEN",
    "NOT", "STEP", "+", "-", "*", "/", "^", "AND",
    "OR", ">", "=", "<", "SGN", "INT", "ABS", "USR",
    "FRE", "POS", "SQR", "RND", "LOG", "EXP", "COS", "SIN",
    "TAN", "ATN", "PEEK", "LEN", "STR$", "VAL", "ASC", "CHR$",
    "LEFT$", "RIGHT$", "MID$", "GO"
  };

  // Keyword length minus one.
  localparam logic [2:0] KW_LEN_M1 [KW_COUNT] = '{
    3'd2, 3'd2, 3'd3, 3'd3, 3'd5, 3'd4, 3'd2, 3'd3,
    3'd2, 3'd3, 3'd2, 3'd1, 3'd6, 3'd4, 3'd5, 3'd2,
    3'd3, 3'd1, 3'd3, 3'd3, 3'd3, 3'd5, 3'd2, 3'd3,
    3'd5, 3'd4, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd3,
    3'd4, 3'd2, 3'd2, 3'd3, 3'd1, 3'd1, 3'd3, 3'd3,
    3'd2, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd2,
    3'd1, 3'd0, 3'd0, 3'd0, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd2, 3'd2, 3'd3,
    3'd4, 3'd5, 3'd3, 3'd1
  };

  function automatic logic [2:0] kw_len_m1(input logic [6:0] idx);
    logic [2:0] len;
    len = 3'd0;
    if (int'(idx) < KW_COUNT) len = KW_LEN_M1[idx];
    return len;
  endfunction

  function automatic logic [7:0] kw_char(input logic [6:0] idx, input logic [2:0] pos);
    logic [2:0] shift;
    logic [7:0] ch;
    ch = 8'h00;
    if (int'(idx) < KW_COUNT) begin
      shift = KW_LEN_M1[idx] - pos;
      ch = KW_TEXT[idx][{shift, 3'b000} +: 8];
    end
    return ch;
  endfunction

  // Decimal weight of digit position 0 (ten thousands) to 4 (units).
  function automatic logic [16:0] pow10(input logic [2:0] pos);
    logic [16:0] w;
    case (pos)
      3'd0:    w = 17'd10000;
      3'd1:    w = 17'd1000;
      3'd2:    w = 17'd100;
      3'd3:    w = 17'd10;
      default: w = 17'd1;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/bpd_stream_if.sv -----
// ----------------------------------------------------------------------------
// Detokenizer stream interfaces
// Valid/ready channels for program bytes in and listing characters out.
// ----------------------------------------------------------------------------
interface bpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_file;

  modport source (output valid, output in_byte, output end_of_file, input ready);
  modport sink   (input valid, input in_byte, input end_of_file, output ready);
endinterface

interface bpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       run_last;

  modport source (output valid, output text_char, output run_last, input ready);
  modport sink   (input valid, input text_char, input run_last, output ready);
endinterface

// ----- rtl/basic_program_detokenizer_core.sv -----
// ----------------------------------------------------------------------------
// BASIC program detokenizer core
// Streams a tokenized BASIC V2 program file in and the listing text out.
// ----------------------------------------------------------------------------
//
//   Channel  Role    Beat payload              Notes
//   -------  ------  ------------------------  ---------------------------------
//   prog     sink    in_byte, end_of_file      one file byte per beat
//   text     source  text_char, run_last       run_last ends a byte's output
//
// The front end takes one beat per cycle whenever the job queue has room.
// The back end takes a job when idle, then emits its characters one by one as
// the text channel accepts them: a line number always walks all five decimal
// positions (leading zeros are suppressed but still take a step each), then a
// space (and a CR when the file ends on it); a keyword has up to seven letters.
// Reset is synchronous and clears the parser, the queue and the output stage.
// A stalled text channel holds the output register and, once the queue fills,
// backs up into prog.ready; each side otherwise stalls on its own.
//
module basic_program_detokenizer_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  bpd_in_if.sink    prog,
  bpd_out_if.source text
);
  import bpd_pkg::*;

  // Jobs waiting between the parser and the character generator.
  job_t push_job;
  job_t head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  // The parser tracks file and line structure and decides per byte what to emit.
  bpd_front u_front (
    .clk  (clk),
    .rst  (rst),
    .prog (prog),
    .push (push),
    .job  (push_job),
    .full (full)
  );

  bpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  // The generator turns numbers into decimal, tokens into keyword text, and
  // appends the trailing CR when the file ends mid-line.
  bpd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .text  (text)
  );

endmodule

// ----- rtl/bpd_front.sv -----
// ----------------------------------------------------------------------------
// Detokenizer front end
// Parses the file header and line headers and turns each line number and body byte into a job.
// ----------------------------------------------------------------------------
module bpd_front (
  input  logic          clk,
  input  logic          rst,
  bpd_in_if.sink        prog,
  output logic          push,
  output bpd_pkg::job_t job,
  input  logic          full
);
  import bpd_pkg::*;

  logic [2:0] phase, phase_next;
  logic       inside_quotes, inside_quotes_next;
  logic [7:0] link_low_byte, link_low_byte_next;
  logic [7:0] line_number_low, line_number_low_next;
  logic       accept;
  logic       quote_now;
  logic [7:0] b;

  assign prog.ready = !full;
  assign accept     = prog.valid && !full;
  assign b          = prog.in_byte;

  always_comb begin
    phase_next           = phase;
    inside_quotes_next   = inside_quotes;
    link_low_byte_next   = link_low_byte;
    line_number_low_next = line_number_low;
    push                 = 1'b0;
    job.kind             = JOB_CHAR;
    job.data             = {8'h00, b};
    job.eof_cr           = prog.end_of_file;
    quote_now            = inside_quotes ^ (b == CH_QUOTE);
    if (accept) begin
      unique case (phase)
        PH_LOAD_LO: phase_next = PH_LOAD_HI;
        PH_LOAD_HI: phase_next = PH_LINK_LO;
        PH_LINK_LO: begin
          link_low_byte_next = b;
          phase_next         = PH_LINK_HI;
        end
        PH_LINK_HI: begin
          phase_next = ((link_low_byte | b) == 8'h00) ? PH_DONE : PH_NUM_LO;
        end
        PH_NUM_LO: begin
          line_number_low_next = b;
          phase_next           = PH_NUM_HI;
        end
        PH_NUM_HI: begin
          push               = 1'b1;
          job.kind           = JOB_NUMBER;
          job.data           = {b, line_number_low};
          inside_quotes_next = 1'b0;
          phase_next         = PH_BODY;
        end
        PH_BODY: begin
          push = 1'b1;
          if (b == 8'h00) begin
            job.kind   = JOB_CR;
            phase_next = PH_LINK_LO;
          end else begin
            inside_quotes_next = quote_now;
            if (!quote_now && b >= KW_FIRST && b <= KW_LAST) job.kind = JOB_KEYWORD;
          end
        end
        default: ;
      endcase
      if (prog.end_of_file) begin
        phase_next           = PH_LOAD_LO;
        inside_quotes_next   = 1'b0;
        link_low_byte_next   = 8'h00;
        line_number_low_next = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LOAD_LO;
      inside_quotes   <= 1'b0;
      link_low_byte   <= 8'h00;
      line_number_low <= 8'h00;
    end else begin
      phase           <= phase_next;
      inside_quotes   <= inside_quotes_next;
      link_low_byte   <= link_low_byte_next;
      line_number_low <= line_number_low_next;
    end
  end

endmodule

// ----- rtl/bpd_queue.sv -----
// ----------------------------------------------------------------------------
// Detokenizer job queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module bpd_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bpd_pkg::job_t push_job,
  input  logic          pop,
  output bpd_pkg::job_t head,
  output logic          full,
  output logic          empty
);
  import bpd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wrap_inc(wr_ptr);
      if (do_pop) rd_ptr <= wrap_inc(rd_ptr);
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// ----- rtl/bpd_back.sv -----
// ----------------------------------------------------------------------------
// Detokenizer back end
// Expands jobs into listing characters through an output register.
// ----------------------------------------------------------------------------
module bpd_back (
  input  logic          clk,
  input  logic          rst,
  input  bpd_pkg::job_t head,
  input  logic          empty,
  output logic          pop,
  bpd_out_if.source     text
);
  import bpd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NUM  = 3'd1;
  localparam logic [2:0] ST_SPC  = 3'd2;
  localparam logic [2:0] ST_BYTE = 3'd3;
  localparam logic [2:0] ST_KW   = 3'd4;
  localparam logic [2:0] ST_CR   = 3'd5;

  logic [2:0]  st, st_next;
  logic [2:0]  pos, pos_next;
  logic [15:0] rem, rem_next;
  logic        started, started_next;
  logic        eof_cr, eof_cr_next;
  logic [7:0]  tok, tok_next;
  logic        o_valid;
  logic [7:0]  o_char;
  logic        o_last;
  logic        can_load;
  logic        emit;
  logic [7:0]  ch;
  logic        last;
  logic [16:0] pw;
  logic [3:0]  digit;
  logic [16:0] sub;
  logic [2:0]  kw_end;

  assign text.valid     = o_valid;
  assign text.text_char = o_char;
  assign text.run_last  = o_last;
  assign can_load       = !o_valid || text.ready;

  // One decimal digit per step: compare against the nine multiples of the weight.
  always_comb begin
    pw    = pow10(pos);
    digit = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if ({1'b0, rem} >= 17'(k) * pw) digit = 4'(k);
    end
    sub = pw * {13'd0, digit};
  end

  assign kw_end = kw_len_m1(tok[6:0]);

  always_comb begin
    st_next      = st;
    pos_next     = pos;
    rem_next     = rem;
    started_next = started;
    eof_cr_next  = eof_cr;
    tok_next     = tok;
    pop          = 1'b0;
    emit         = 1'b0;
    ch           = CH_CR;
    last         = 1'b0;
    unique case (st)
      ST_IDLE: begin
        if (!empty) begin
          pop          = 1'b1;
          eof_cr_next  = head.eof_cr;
          rem_next     = head.data;
          tok_next     = head.data[7:0];
          pos_next     = 3'd0;
          started_next = 1'b0;
          unique case (head.kind)
            JOB_NUMBER:  st_next = ST_NUM;
            JOB_CHAR:    st_next = ST_BYTE;
            JOB_KEYWORD: st_next = ST_KW;
            default:     st_next = ST_CR;
          endcase
        end
      end
      ST_NUM: begin
        if (can_load) begin
          emit         = started || (digit != 4'd0) || (pos == 3'd4);
          ch           = CH_ZERO + {4'd0, digit};
          rem_next     = 16'(({1'b0, rem}) - sub);
          started_next = started || emit;
          pos_next     = pos + 3'd1;
          if (pos == 3'd4) st_next = ST_SPC;
        end
      end
      ST_SPC, ST_BYTE: begin
        if (can_load) begin
          emit    = 1'b1;
          ch      = (st == ST_SPC) ? CH_SPACE : tok;
          last    = !eof_cr;
          st_next = eof_cr ? ST_CR : ST_IDLE;
        end
      end
      ST_KW: begin
        if (can_load) begin
          emit = 1'b1;
          ch   = kw_char(tok[6:0], pos);
          if (pos == kw_end) begin
            last    = !eof_cr;
            st_next = eof_cr ? ST_CR : ST_IDLE;
          end else begin
            pos_next = pos + 3'd1;
          end
        end
      end
      ST_CR: begin
        if (can_load) begin
          emit    = 1'b1;
          ch      = CH_CR;
          last    = 1'b1;
          st_next = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    pos     <= pos_next;
    rem     <= rem_next;
    started <= started_next;
    eof_cr  <= eof_cr_next;
    tok     <= tok_next;
    if (emit) begin
      o_char <= ch;
      o_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= ST_IDLE;
      o_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (emit) o_valid <= 1'b1;
      else if (text.ready) o_valid <= 1'b0;
    end
  end

  a_num_pos: assert property (@(posedge clk) disable iff (rst)
    (st == ST_NUM) |-> (pos <= 3'd4))
    else $error("digit position ran past the units digit");

  a_kw_pos: assert property (@(posedge clk) disable iff (rst)
    (st == ST_KW) |-> (pos <= kw_end))
    else $error("keyword position ran past the keyword end");

  a_units_digit: assert property (@(posedge clk) disable iff (rst)
    (st == ST_NUM && pos == 3'd4 && can_load) |=> (o_valid && st == ST_SPC))
    else $error("units digit of a line number was not emitted");

endmodule
